// ===== rtl/swkd_pkg.sv =====
`default_nettype none

package swkd_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_ITEMS_DEF  = 1024;
    localparam int VALUE_BITS_DEF = 10;

    // Fixed field widths
    localparam int VALUE_W   = 10;
    localparam int NEED_W    = 11;
    localparam int LEN_W     = 11;
    localparam int POS_W     = 10;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 32;

    // Config port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_DISTINCT_NEEDED = 1'b0;   // register index, from paddr[2]
    localparam logic [NEED_W-1:0] NEED_RESET = 11'd1;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_SH_CHK,
        ST_SH_KEY,
        ST_SH_DEC,
        ST_EMIT,
        ST_CLR_CHK,
        ST_CLR_KEY
    } swkd_state_t;

    typedef struct packed {
        logic init_step;   // zero one count entry
        logic accept;      // input item taken
        logic add_rd;      // read count of new key
        logic add_wr;      // write count+1
        logic sh_best;     // compare window, read leftmost element
        logic sh_key;      // read count of leftmost key
        logic sh_dec;      // write count-1, advance left edge
        logic emit;        // load output register
        logic clr_rd;      // read element during cleanup
        logic clr_wr;      // zero its count
        logic finish;      // clear per-set registers
    } swkd_cmd_t;

    typedef struct packed {
        logic init_done;
        logic room;
        logic last;
        logic shrink_go;
        logic clr_go;
        logic out_free;
    } swkd_status_t;

endpackage

`default_nettype wire

// ===== rtl/swkd_ctrl.sv =====
`default_nettype none

module swkd_ctrl
    import swkd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire logic         in_last,
    output logic              in_ready,
    input  wire swkd_status_t status,
    output swkd_cmd_t         cmd
);

    swkd_state_t state_reg;
    swkd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (status.init_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (status.room)
                    begin
                        state_next = ST_ADD_RD;
                    end
                    else if (in_last)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_ADD_RD: state_next = ST_ADD_WR;
            ST_ADD_WR: state_next = ST_SH_CHK;
            ST_SH_CHK:
            begin
                if (status.shrink_go)
                begin
                    state_next = ST_SH_KEY;
                end
                else if (status.last)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SH_KEY: state_next = ST_SH_DEC;
            ST_SH_DEC: state_next = ST_SH_CHK;
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_CLR_CHK;
                end
            end
            ST_CLR_CHK:
            begin
                state_next = status.clr_go ? ST_CLR_KEY : ST_IDLE;
            end
            ST_CLR_KEY: state_next = ST_CLR_CHK;
            default:    state_next = ST_INIT;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_INIT:    cmd.init_step = 1'b1;
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_ADD_RD:  cmd.add_rd = 1'b1;
            ST_ADD_WR:  cmd.add_wr = 1'b1;
            ST_SH_CHK:  cmd.sh_best = status.shrink_go;
            ST_SH_KEY:  cmd.sh_key = 1'b1;
            ST_SH_DEC:  cmd.sh_dec = 1'b1;
            ST_EMIT:    cmd.emit = status.out_free;
            ST_CLR_CHK:
            begin
                cmd.clr_rd = status.clr_go;
                cmd.finish = !status.clr_go;
            end
            ST_CLR_KEY: cmd.clr_wr = 1'b1;
            default:    cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/swkd_dp.sv =====
`default_nettype none

module swkd_dp
    import swkd_pkg::*;
#(
    parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire swkd_cmd_t          cmd,
    output swkd_status_t            status,
    input  wire logic [VALUE_W-1:0] in_value,
    input  wire logic               in_last,
    input  wire logic [NEED_W-1:0]  distinct_needed,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    out_found,
    output logic [LEN_W-1:0]        out_length,
    output logic [POS_W-1:0]        out_left,
    output logic [POS_W-1:0]        out_right
);

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int KEYS  = 1 << VALUE_BITS;
    localparam int CMP_W = (CNT_W > NEED_W) ? CNT_W : NEED_W;

    // Element buffer (no reset) and per-key occurrence counts
    logic [VALUE_BITS-1:0] elem_mem [MAX_ITEMS];
    logic [CNT_W-1:0]      cnt_mem  [KEYS];

    logic [VALUE_BITS-1:0] elem_q;
    logic [CNT_W-1:0]      cnt_q;

    logic [VALUE_BITS-1:0] init_ptr_reg;
    logic [VALUE_BITS-1:0] key_reg;
    logic                  last_reg;
    logic [CNT_W-1:0]      wi_reg;
    logic [CNT_W-1:0]      wl_reg;
    logic [IDX_W-1:0]      right_reg;
    logic [CNT_W-1:0]      distinct_reg;
    logic                  found_reg;
    logic [CNT_W-1:0]      best_len_reg;
    logic [IDX_W-1:0]      best_left_reg;
    logic [IDX_W-1:0]      best_right_reg;
    logic                  out_valid_reg;
    logic                  out_found_reg;
    logic [LEN_W-1:0]      out_length_reg;
    logic [POS_W-1:0]      out_left_reg;
    logic [POS_W-1:0]      out_right_reg;

    logic                  elem_we;
    logic                  elem_re;
    logic                  cnt_we;
    logic                  cnt_re;
    logic [VALUE_BITS-1:0] cnt_waddr;
    logic [VALUE_BITS-1:0] cnt_raddr;
    logic [CNT_W-1:0]      cnt_wdata;
    logic [NEED_W-1:0]     need;
    logic [CNT_W-1:0]      win_len;
    logic                  better;

    assign need    = (distinct_needed == '0) ? NEED_RESET : distinct_needed;
    assign win_len = CNT_W'(right_reg) - wl_reg + CNT_W'(1);
    assign better  = !found_reg || (win_len < best_len_reg);

    assign status.init_done = (init_ptr_reg == '1);
    assign status.room      = (wi_reg < CNT_W'(MAX_ITEMS));
    assign status.last      = last_reg;
    assign status.shrink_go = (CMP_W'(distinct_reg) >= CMP_W'(need))
                              && (wl_reg <= CNT_W'(right_reg));
    assign status.clr_go    = (wl_reg < wi_reg);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign elem_we = cmd.accept && status.room;
    assign elem_re = cmd.sh_best || cmd.clr_rd;
    assign cnt_re  = cmd.add_rd || cmd.sh_key;
    assign cnt_raddr = cmd.add_rd ? key_reg : elem_q;

    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_waddr = elem_q;
        cnt_wdata = '0;
        priority if (cmd.init_step)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = init_ptr_reg;
        end
        else if (cmd.add_wr)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = key_reg;
            cnt_wdata = cnt_q + CNT_W'(1);
        end
        else if (cmd.sh_dec)
        begin
            cnt_we    = (cnt_q != '0);
            cnt_wdata = cnt_q - CNT_W'(1);
        end
        else if (cmd.clr_wr)
        begin
            cnt_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (elem_we)
        begin
            elem_mem[wi_reg[IDX_W-1:0]] <= VALUE_BITS'(in_value);
        end
        if (elem_re)
        begin
            elem_q <= elem_mem[wl_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re)
        begin
            cnt_q <= cnt_mem[cnt_raddr];
        end
    end

    // Captured item, best-window payload and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            key_reg   <= VALUE_BITS'(in_value);
            last_reg  <= in_last;
            right_reg <= wi_reg[IDX_W-1:0];
        end
        if (cmd.sh_best && better)
        begin
            best_len_reg   <= win_len;
            best_left_reg  <= wl_reg[IDX_W-1:0];
            best_right_reg <= right_reg;
        end
        if (cmd.emit)
        begin
            out_found_reg  <= found_reg;
            out_length_reg <= found_reg ? LEN_W'(best_len_reg) : '0;
            out_left_reg   <= found_reg ? POS_W'(best_left_reg) : '0;
            out_right_reg  <= found_reg ? POS_W'(best_right_reg) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_ptr_reg  <= '0;
            wi_reg        <= '0;
            wl_reg        <= '0;
            distinct_reg  <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.init_step)
            begin
                init_ptr_reg <= init_ptr_reg + VALUE_BITS'(1);
            end
            if (cmd.add_wr)
            begin
                wi_reg <= wi_reg + CNT_W'(1);
                if (cnt_q == '0)
                begin
                    distinct_reg <= distinct_reg + CNT_W'(1);
                end
            end
            if (cmd.sh_best)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.sh_dec)
            begin
                wl_reg <= wl_reg + CNT_W'(1);
                if ((cnt_q == CNT_W'(1)) && (distinct_reg != '0))
                begin
                    distinct_reg <= distinct_reg - CNT_W'(1);
                end
            end
            if (cmd.clr_wr)
            begin
                wl_reg <= wl_reg + CNT_W'(1);
            end
            if (cmd.finish)
            begin
                wi_reg       <= '0;
                wl_reg       <= '0;
                distinct_reg <= '0;
                found_reg    <= 1'b0;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_found  = out_found_reg;
    assign out_length = out_length_reg;
    assign out_left   = out_left_reg;
    assign out_right  = out_right_reg;

    // Left edge never passes the fill point
    a_left_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
        wl_reg <= wi_reg)
        else $error("window left edge beyond write index");

    // A key dropped from the window must have a nonzero count
    a_drop_counted: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sh_dec |-> (cnt_q != '0))
        else $error("dropping a key whose count is zero");

    // A recorded best window is non-empty and inside the stored items
    a_best_sane: assert property (@(posedge clk) disable iff (!rst_n)
        (found_reg && !cmd.sh_best) |->
            ((best_len_reg != '0) && (best_len_reg <= wi_reg)))
        else $error("best window length out of range");

    // Emitting never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

endmodule

`default_nettype wire

// ===== rtl/shortest_window_k_distinct_core.sv =====
// Per item: accept, count read, count write and window check; then, per element dropped
//   from the window's left: key read, count decrement, check again; each is dropped once.
// A last item then loads the result (later while an earlier result waits), then zeroes the
//   count of each element still in the window and clears the per-set registers.
// Throughput: a new item is taken only after the previous one has been counted and checked.
// Reset: async, active low; then the whole count memory is zeroed, with s_tready low.
`default_nettype none

module shortest_window_k_distinct_core
    import swkd_pkg::*;
#(
    parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Input items
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [S_DATA_W-1:0]    s_tdata,    // [9:0] value, [15:10] zero
    input  wire logic                   s_tlast,    // last item of the set
    // Result items
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [M_DATA_W-1:0]         m_tdata,    // [0] found, [11:1] best_length,
                                                    // [21:12] best_left, [31:22] best_right
    // APB config
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [CFG_ADDR_W-1:0]  paddr,
    input  wire logic [CFG_DATA_W-1:0]  pwdata,
    output logic [CFG_DATA_W-1:0]       prdata,
    output logic                        pready
);

    swkd_cmd_t         cmd;
    swkd_status_t      status;
    logic [NEED_W-1:0] need_reg;
    logic              cfg_wr;

    logic              out_found;
    logic [LEN_W-1:0]  out_length;
    logic [POS_W-1:0]  out_left;
    logic [POS_W-1:0]  out_right;

    // distinct_needed register, byte address 0
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == REG_DISTINCT_NEEDED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            need_reg <= NEED_RESET;
        end
        else if (cfg_wr)
        begin
            need_reg <= pwdata[NEED_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_DISTINCT_NEEDED) ? CFG_DATA_W'(need_reg) : '0;

    swkd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    swkd_dp #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .in_value        (s_tdata[VALUE_W-1:0]),
        .in_last         (s_tlast),
        .distinct_needed (need_reg),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_found       (out_found),
        .out_length      (out_length),
        .out_left        (out_left),
        .out_right       (out_right)
    );

    // Fields packed from bit 0 up, 32 bits in all
    assign m_tdata = {out_right, out_left, out_length, out_found};

endmodule

`default_nettype wire
